FILE: sv/rsa_pkg.sv
// rsa_pkg: shared sizes, codes and payload types of the running statistics accumulator
// no dependencies; every other file of the block imports this package

package rsa_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 24;
    localparam int TOTAL_BITS  = SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_BITS     = 2 * SAMPLE_BITS + COUNT_BITS - 1;
    localparam int VAR_BITS    = 2 * SAMPLE_BITS - 1;
    localparam int PROD_BITS   = 2 * TOTAL_BITS;
    localparam int DVS_BITS    = 2 * COUNT_BITS;
    localparam int STEP_MAX    = (TOTAL_BITS > VAR_BITS) ? TOTAL_BITS : VAR_BITS;
    localparam int STEP_BITS   = $clog2(STEP_MAX + 1);

    localparam logic [STEP_BITS-1:0] STEPS_SAMPLE = STEP_BITS'(SAMPLE_BITS);
    localparam logic [STEP_BITS-1:0] STEPS_COUNT  = STEP_BITS'(COUNT_BITS);
    localparam logic [STEP_BITS-1:0] STEPS_TOTAL  = STEP_BITS'(TOTAL_BITS);
    localparam logic [STEP_BITS-1:0] STEPS_VAR    = STEP_BITS'(VAR_BITS);

    // empty-accumulator values of min and max
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // action field codes
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef enum logic [0:0] {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic                          action;
        logic signed [SAMPLE_BITS-1:0] sample;
    } rsa_in_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]         count;
        logic signed [TOTAL_BITS-1:0]  total;
        logic [SQ_BITS-1:0]            total_squares;
        logic signed [SAMPLE_BITS-1:0] smallest;
        logic signed [SAMPLE_BITS-1:0] largest;
        logic                          all_equal;
        logic signed [SAMPLE_BITS-1:0] average;
        logic [VAR_BITS-1:0]           pop_variance;
        logic [VAR_BITS-1:0]           unbiased_variance;
        logic                          full_res;
    } rsa_out_t;

    // accumulated statistics as seen by the sequencer
    typedef struct packed {
        logic [COUNT_BITS-1:0]         count;
        logic signed [TOTAL_BITS-1:0]  total;
        logic [SQ_BITS-1:0]            total_squares;
        logic signed [SAMPLE_BITS-1:0] smallest;
        logic signed [SAMPLE_BITS-1:0] largest;
        logic                          all_equal;
        logic [TOTAL_BITS-1:0]         magnitude;
        logic                          full;
    } rsa_stats_t;

    // command to the shared shift-add / restoring-divide unit
    typedef struct packed {
        logic                  start;
        alu_op_t               op;
        logic                  sub;
        logic [PROD_BITS-1:0]  mcand;
        logic [TOTAL_BITS-1:0] mplier;
        logic [PROD_BITS-1:0]  init;
        logic [DVS_BITS-1:0]   div_hi;
        logic [VAR_BITS-1:0]   div_lo;
        logic [DVS_BITS-1:0]   divisor;
        logic [STEP_BITS-1:0]  steps;
    } alu_req_t;

    typedef struct packed {
        logic                 done;
        logic [PROD_BITS-1:0] product;
        logic [VAR_BITS-1:0]  quotient;
    } alu_rsp_t;

endpackage

FILE: sv/rsa_if.sv
// rsa_item_if, rsa_result_if: valid/ready stream channels of the accumulator
// depends on rsa_pkg for the payload types

interface rsa_item_if;
    import rsa_pkg::*;

    logic    valid;
    logic    ready;
    rsa_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rsa_result_if;
    import rsa_pkg::*;

    logic     valid;
    logic     ready;
    rsa_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/rsa_stats.sv
// rsa_stats: count, sum, sum of squares, min, max and all-equal registers
// depends on rsa_pkg

module rsa_stats (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                upd,
    input  rsa_pkg::rsa_in_t    item_data,
    output rsa_pkg::rsa_stats_t st
);
    import rsa_pkg::*;

    logic [COUNT_BITS-1:0]         count_reg;
    logic signed [TOTAL_BITS-1:0]  total_reg;
    logic [SQ_BITS-1:0]            sumsq_reg;
    logic signed [SAMPLE_BITS-1:0] min_reg;
    logic signed [SAMPLE_BITS-1:0] max_reg;
    logic                          eq_reg;
    logic signed [SAMPLE_BITS-1:0] prev_reg;
    logic [VAR_BITS-1:0]           sq_reg;
    logic                          sq_pend_reg;

    logic                          full;
    logic                          clr;
    logic                          take;
    logic signed [SAMPLE_BITS-1:0] s;
    logic signed [2*SAMPLE_BITS-1:0] square;
    logic [TOTAL_BITS-1:0]         total_u;
    logic                          eq_next;

    assign s      = item_data.sample;
    assign full   = &count_reg;
    assign clr    = upd && (item_data.action == ACT_CLEAR);
    assign take   = upd && (item_data.action == ACT_ADD) && !full;
    assign square = s * s;
    assign eq_next = (count_reg == '0) ? 1'b1 : (eq_reg && (prev_reg == s));
    assign total_u = total_reg;

    // statistics registers; the square is registered and added in the cycle after the sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            total_reg   <= '0;
            sumsq_reg   <= '0;
            min_reg     <= SMP_MAX;
            max_reg     <= SMP_MIN;
            eq_reg      <= 1'b1;
            prev_reg    <= '0;
            sq_pend_reg <= 1'b0;
        end
        else if (clr)
        begin
            count_reg   <= '0;
            total_reg   <= '0;
            sumsq_reg   <= '0;
            min_reg     <= SMP_MAX;
            max_reg     <= SMP_MIN;
            eq_reg      <= 1'b1;
            prev_reg    <= '0;
            sq_pend_reg <= 1'b0;
        end
        else
        begin
            sq_pend_reg <= take;
            if (sq_pend_reg)
            begin
                sumsq_reg <= sumsq_reg + SQ_BITS'(sq_reg);
            end
            if (take)
            begin
                count_reg <= count_reg + COUNT_BITS'(1);
                total_reg <= total_reg + {{(TOTAL_BITS-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
                if (s < min_reg)
                begin
                    min_reg <= s;
                end
                if (s > max_reg)
                begin
                    max_reg <= s;
                end
                eq_reg   <= eq_next;
                prev_reg <= s;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sq_reg <= square[VAR_BITS-1:0];
        end
    end

    always_comb
    begin
        st.count         = count_reg;
        st.total         = total_reg;
        st.total_squares = sumsq_reg;
        st.smallest      = min_reg;
        st.largest       = max_reg;
        st.all_equal     = eq_reg;
        st.magnitude     = total_reg[TOTAL_BITS-1] ? (~total_u + TOTAL_BITS'(1)) : total_u;
        st.full          = full;
    end

endmodule

FILE: sv/rsa_alu.sv
// rsa_alu: shared one-bit-per-cycle unit, shift-add multiply and restoring divide
// depends on rsa_pkg; one adder serves both operations

module rsa_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  rsa_pkg::alu_req_t req,
    output rsa_pkg::alu_rsp_t rsp
);
    import rsa_pkg::*;

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_MUL  = 4'b0010,
        A_CHK  = 4'b0100,
        A_DIV  = 4'b1000
    } alu_state_t;

    alu_state_t            state_reg;
    logic                  done_reg;
    logic [STEP_BITS-1:0]  cnt_reg;
    logic [PROD_BITS-1:0]  acc_reg;
    logic [PROD_BITS-1:0]  mcand_reg;
    logic [TOTAL_BITS-1:0] mplier_reg;
    logic                  sub_reg;
    logic [DVS_BITS-1:0]   rem_reg;
    logic [VAR_BITS-1:0]   lo_reg;
    logic [DVS_BITS-1:0]   dvs_reg;
    logic [VAR_BITS-1:0]   quo_reg;

    logic [PROD_BITS-1:0]  add_x;
    logic [PROD_BITS-1:0]  add_y;
    logic                  add_sub;
    logic [PROD_BITS:0]    add_sum;
    logic [DVS_BITS:0]     rem_sh;
    logic                  geq;
    logic                  last;

    assign rem_sh  = {rem_reg, lo_reg[VAR_BITS-1]};
    assign add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                   + {{PROD_BITS{1'b0}}, add_sub};
    assign geq     = add_sum[PROD_BITS];
    assign last    = (cnt_reg == STEP_BITS'(1));

    // operand select of the shared adder
    always_comb
    begin
        add_x   = acc_reg;
        add_y   = mcand_reg;
        add_sub = sub_reg;
        unique case (state_reg)
            A_CHK:
            begin
                add_x   = PROD_BITS'(rem_reg);
                add_y   = PROD_BITS'(dvs_reg);
                add_sub = 1'b1;
            end
            A_DIV:
            begin
                add_x   = PROD_BITS'(rem_sh);
                add_y   = PROD_BITS'(dvs_reg);
                add_sub = 1'b1;
            end
            default:
            begin
                add_sub = sub_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                A_IDLE:
                begin
                    if (req.start)
                    begin
                        state_reg <= (req.op == ALU_MUL) ? A_MUL : A_CHK;
                    end
                end
                A_MUL:
                begin
                    if (last)
                    begin
                        state_reg <= A_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                A_CHK:
                begin
                    // high part not below the divisor: quotient does not fit, saturate
                    if (geq)
                    begin
                        state_reg <= A_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= A_DIV;
                    end
                end
                A_DIV:
                begin
                    if (last)
                    begin
                        state_reg <= A_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    cnt_reg    <= req.steps;
                    acc_reg    <= req.init;
                    mcand_reg  <= req.mcand;
                    mplier_reg <= req.mplier;
                    sub_reg    <= req.sub;
                    rem_reg    <= req.div_hi;
                    lo_reg     <= req.div_lo;
                    dvs_reg    <= req.divisor;
                    quo_reg    <= '0;
                end
            end
            A_MUL:
            begin
                if (mplier_reg[0])
                begin
                    acc_reg <= add_sum[PROD_BITS-1:0];
                end
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                cnt_reg    <= cnt_reg - STEP_BITS'(1);
            end
            A_CHK:
            begin
                if (geq)
                begin
                    quo_reg <= '1;
                end
            end
            A_DIV:
            begin
                if (geq)
                begin
                    rem_reg <= add_sum[DVS_BITS-1:0];
                end
                else
                begin
                    rem_reg <= rem_sh[DVS_BITS-1:0];
                end
                lo_reg  <= lo_reg << 1;
                quo_reg <= {quo_reg[VAR_BITS-2:0], geq};
                cnt_reg <= cnt_reg - STEP_BITS'(1);
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    always_comb
    begin
        rsp.done     = done_reg;
        rsp.product  = acc_reg;
        rsp.quotient = quo_reg;
    end

endmodule

FILE: sv/rsa_seq.sv
// rsa_seq: sequencer that runs the mean and variance steps on the shared unit
// depends on rsa_pkg; drives rsa_alu and holds the result register

module rsa_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_action,
    output logic                item_ready,
    input  rsa_pkg::rsa_stats_t st,
    output rsa_pkg::alu_req_t   req,
    input  rsa_pkg::alu_rsp_t   rsp,
    input  logic                result_ready,
    output logic                result_valid,
    output rsa_pkg::rsa_out_t   result_data
);
    import rsa_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_AVG  = 9'b000000010,
        S_MNS  = 9'b000000100,
        S_MMM  = 9'b000001000,
        S_MNN  = 9'b000010000,
        S_POP  = 9'b000100000,
        S_MNM  = 9'b001000000,
        S_UNB  = 9'b010000000,
        S_DONE = 9'b100000000
    } seq_state_t;

    seq_state_t                    state_reg;
    logic                          issued_reg;
    logic                          full_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] avg_reg;
    logic [VAR_BITS-1:0]           pop_reg;
    logic [VAR_BITS-1:0]           unb_reg;
    logic [PROD_BITS-1:0]          prod_reg;
    logic [DVS_BITS-1:0]           dvs_reg;
    rsa_out_t                      out_reg;

    logic                   accept;
    logic                   empty;
    logic                   single;
    logic                   op_state;
    logic                   load;
    logic [SAMPLE_BITS-1:0] q_s;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign empty      = (st.count == '0);
    assign single     = (st.count == COUNT_BITS'(1));
    assign op_state   = (state_reg != S_IDLE) && (state_reg != S_DONE);
    assign load       = (state_reg == S_DONE) && (!out_valid_reg || result_ready);
    assign q_s        = rsp.quotient[SAMPLE_BITS-1:0];

    // operands for the step of the current state
    always_comb
    begin
        req       = '0;
        req.op    = ALU_MUL;
        req.start = op_state && !issued_reg && !((state_reg == S_AVG) && empty);
        unique case (state_reg)
            S_AVG:
            begin
                req.op      = ALU_DIV;
                req.div_hi  = DVS_BITS'(st.magnitude[TOTAL_BITS-1:SAMPLE_BITS]);
                req.div_lo  = {st.magnitude[SAMPLE_BITS-1:0],
                               {(VAR_BITS-SAMPLE_BITS){1'b0}}};
                req.divisor = DVS_BITS'(st.count);
                req.steps   = STEPS_SAMPLE;
            end
            S_MNS:
            begin
                req.mcand  = PROD_BITS'(st.total_squares);
                req.mplier = TOTAL_BITS'(st.count);
                req.steps  = STEPS_COUNT;
            end
            S_MMM:
            begin
                // n*sumsq minus sum squared, accumulated in place
                req.mcand  = PROD_BITS'(st.magnitude);
                req.mplier = st.magnitude;
                req.init   = prod_reg;
                req.sub    = 1'b1;
                req.steps  = STEPS_TOTAL;
            end
            S_MNN:
            begin
                req.mcand  = PROD_BITS'(st.count);
                req.mplier = TOTAL_BITS'(st.count);
                req.steps  = STEPS_COUNT;
            end
            S_POP, S_UNB:
            begin
                req.op      = ALU_DIV;
                req.div_hi  = prod_reg[VAR_BITS +: DVS_BITS];
                req.div_lo  = prod_reg[VAR_BITS-1:0];
                req.divisor = dvs_reg;
                req.steps   = STEPS_VAR;
            end
            S_MNM:
            begin
                req.mcand  = PROD_BITS'(st.count);
                req.mplier = TOTAL_BITS'(st.count - COUNT_BITS'(1));
                req.steps  = STEPS_COUNT;
            end
            S_IDLE, S_DONE:
            begin
                req.steps = '0;
            end
            default:
            begin
                req.steps = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issued_reg    <= 1'b0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.start)
            begin
                issued_reg <= 1'b1;
            end
            if (op_state && rsp.done)
            begin
                issued_reg <= 1'b0;
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        full_reg  <= (item_action == ACT_ADD) && st.full;
                        state_reg <= S_AVG;
                    end
                end
                S_AVG:
                begin
                    if (empty)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (rsp.done)
                    begin
                        state_reg <= S_MNS;
                    end
                end
                S_MNS:
                begin
                    if (rsp.done)
                    begin
                        state_reg <= S_MMM;
                    end
                end
                S_MMM:
                begin
                    if (rsp.done)
                    begin
                        state_reg <= S_MNN;
                    end
                end
                S_MNN:
                begin
                    if (rsp.done)
                    begin
                        state_reg <= S_POP;
                    end
                end
                S_POP:
                begin
                    if (rsp.done)
                    begin
                        state_reg <= single ? S_DONE : S_MNM;
                    end
                end
                S_MNM:
                begin
                    if (rsp.done)
                    begin
                        state_reg <= S_UNB;
                    end
                end
                S_UNB:
                begin
                    if (rsp.done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // step results and the output register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            avg_reg <= '0;
            pop_reg <= '0;
            unb_reg <= '0;
        end
        if (rsp.done)
        begin
            unique case (state_reg)
                S_AVG:
                begin
                    avg_reg <= st.total[TOTAL_BITS-1] ? (~q_s + SAMPLE_BITS'(1)) : q_s;
                end
                S_MNS, S_MMM:
                begin
                    prod_reg <= rsp.product;
                end
                S_MNN, S_MNM:
                begin
                    dvs_reg <= rsp.product[DVS_BITS-1:0];
                end
                S_POP:
                begin
                    pop_reg <= rsp.quotient;
                end
                S_UNB:
                begin
                    unb_reg <= rsp.quotient;
                end
                default:
                begin
                    prod_reg <= prod_reg;
                end
            endcase
        end
        if (load)
        begin
            out_reg.count             <= st.count;
            out_reg.total             <= st.total;
            out_reg.total_squares     <= st.total_squares;
            out_reg.smallest          <= st.smallest;
            out_reg.largest           <= st.largest;
            out_reg.all_equal         <= st.all_equal;
            out_reg.average           <= avg_reg;
            out_reg.pop_variance      <= pop_reg;
            out_reg.unbiased_variance <= unb_reg;
            out_reg.full_res          <= full_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule

FILE: sv/running_statistics_accumulator.sv
// running_statistics_accumulator: top level of the running mean / variance / min / max block
// depends on rsa_pkg, rsa_if, rsa_stats, rsa_alu and rsa_seq

// Each beat on item either adds a signed sample (action 0) or clears all statistics
// (action 1, sample ignored); every beat produces exactly one beat on result carrying
// count, exact sum, exact sum of squares, min, max, the all-equal flag, the mean
// truncated toward zero, the population variance floor((n*sumsq - sum^2)/n^2) and the
// unbiased variance floor((n*sumsq - sum^2)/(n*(n-1))). Mean and variances read 0 when
// they are undefined (no samples, or one sample for the unbiased variance). A sample
// that arrives with the count already at its maximum changes nothing and sets full_res.
// Samples are accumulated in registers; the mean and variances are then worked out on
// a single shared shift-add / restoring-divide unit that retires one bit per cycle,
// and that unit sets the rate. An item that leaves a single sample in the accumulator
// skips the unbiased-variance steps, and a clear skips all of the mean and variance
// steps. item.ready is high only while the sequencer is idle. The result sits in an
// output register, so the next item is taken while an earlier result waits on
// result.ready. No clearing pass is needed after reset.

module running_statistics_accumulator (
    input  logic         clk,
    input  logic         rst_n,
    rsa_item_if.sink     item,
    rsa_result_if.source result
);
    import rsa_pkg::*;

    rsa_stats_t st;
    alu_req_t   req;
    alu_rsp_t   rsp;
    logic       ready;
    logic       accept;

    // state update happens on the same edge that takes the beat
    assign accept     = item.valid && ready;
    assign item.ready = ready;

    // count, sums, min, max and the all-equal flag
    rsa_stats u_stats (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (accept),
        .item_data (item.data),
        .st        (st)
    );

    // shared bit-serial multiply / divide unit
    rsa_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // mean, n*sumsq - sum^2, n^2 and the population divide, then n*(n-1) and the unbiased divide
    rsa_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_action  (item.data.action),
        .item_ready   (ready),
        .st           (st),
        .req          (req),
        .rsp          (rsp),
        .result_ready (result.ready),
        .result_valid (result.valid),
        .result_data  (result.data)
    );

endmodule

FILE: sv/rsa_checker.sv
// rsa_checker: port-level assertions on the running statistics accumulator
// depends on rsa_pkg; bound to running_statistics_accumulator below

module rsa_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input logic              result_valid,
    input logic              result_ready,
    input rsa_pkg::rsa_out_t result_data
);
    import rsa_pkg::*;

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result beat changed while stalled");

    // the block is busy right after taking a beat
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken on consecutive cycles");

    // empty statistics report zero mean and variances
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_data.count == '0) |->
            (result_data.average == '0) && (result_data.pop_variance == '0)
            && (result_data.unbiased_variance == '0) && result_data.all_equal
            && !result_data.full_res)
        else $error("nonzero statistics on an empty accumulator");

    // one sample: no spread
    a_single_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_data.count == COUNT_BITS'(1)) |->
            (result_data.unbiased_variance == '0) && (result_data.pop_variance == '0)
            && result_data.all_equal)
        else $error("spread reported for a single sample");

    // an ignored sample only happens at a saturated count
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.full_res |-> (&result_data.count))
        else $error("full_res with count below its maximum");

endmodule

bind running_statistics_accumulator rsa_checker u_rsa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);

FILE: tb/rsa_stats_checker.sv
// rsa_stats_checker: predicts the running statistics for every accepted item beat and
// compares each result beat field by field; depends on rsa_pkg and rsa_if

module rsa_stats_checker (
    input  logic  clk,
    input  logic  rst_n,
    rsa_item_if   item,
    rsa_result_if result,
    output int    fail_count,
    output int    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rsa_pkg::*;

    localparam logic [127:0] VAR_LIMIT = (128'(1) << VAR_BITS) - 128'(1);

    // predicted accumulator state
    logic [COUNT_BITS-1:0]         n_acc;
    logic signed [TOTAL_BITS-1:0]  sum_acc;
    logic [SQ_BITS-1:0]            sq_acc;
    logic signed [SAMPLE_BITS-1:0] min_acc;
    logic signed [SAMPLE_BITS-1:0] max_acc;
    logic signed [SAMPLE_BITS-1:0] prev_acc;
    logic                          eq_acc;

    rsa_out_t expected_stats_q[$];
    int       result_index;

    function automatic void clear_stats();
        n_acc    = '0;
        sum_acc  = '0;
        sq_acc   = '0;
        min_acc  = SMP_MAX;
        max_acc  = SMP_MIN;
        prev_acc = '0;
        eq_acc   = 1'b1;
    endfunction

    // applies one item to the predicted state and returns the statistics it reports
    function automatic rsa_out_t advance_stats(rsa_in_t it);
        rsa_out_t                      r;
        logic signed [SAMPLE_BITS-1:0] s;
        logic signed [31:0]            prod;
        logic [TOTAL_BITS-1:0]         mag;
        logic [TOTAL_BITS-1:0]         q;
        logic [127:0]                  diff;
        logic [127:0]                  quo;
        r = '0;
        s = it.sample;
        if (it.action == ACT_CLEAR) begin
            clear_stats();
        end
        else if (n_acc == {COUNT_BITS{1'b1}}) begin
            r.full_res = 1'b1;
        end
        else begin
            prod    = s * s;
            sum_acc = sum_acc + s;
            sq_acc  = sq_acc + SQ_BITS'($unsigned(prod));
            n_acc   = n_acc + 1'b1;
            if (s < min_acc) min_acc = s;
            if (s > max_acc) max_acc = s;
            eq_acc   = (n_acc == 1) ? 1'b1 : (eq_acc && (prev_acc == s));
            prev_acc = s;
        end

        r.count         = n_acc;
        r.total         = sum_acc;
        r.total_squares = sq_acc;
        r.smallest      = min_acc;
        r.largest       = max_acc;
        r.all_equal     = eq_acc;
        if (n_acc != 0) begin
            mag = (sum_acc < 0) ? TOTAL_BITS'(-sum_acc) : TOTAL_BITS'(sum_acc);
            q   = mag / TOTAL_BITS'(n_acc);
            r.average = (sum_acc < 0) ? SAMPLE_BITS'(-q) : SAMPLE_BITS'(q);
            // n*sumsq - sum^2 is never negative, exact in 128 bits
            diff = 128'(n_acc) * 128'(sq_acc) - 128'(mag) * 128'(mag);
            quo  = diff / (128'(n_acc) * 128'(n_acc));
            r.pop_variance = (quo > VAR_LIMIT) ? VAR_BITS'(VAR_LIMIT) : VAR_BITS'(quo);
            if (n_acc > 1) begin
                quo = diff / (128'(n_acc) * 128'(n_acc - 1'b1));
                r.unbiased_variance = (quo > VAR_LIMIT) ? VAR_BITS'(VAR_LIMIT)
                                                        : VAR_BITS'(quo);
            end
        end
        return r;
    endfunction

    task automatic check_field(string label, logic [63:0] want_v, logic [63:0] got_v);
        if (want_v !== got_v) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch result %0d %s: expected %h got %h",
                         result_index, label, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        rsa_out_t want;
        rsa_out_t got;
        if (!rst_n) begin
            clear_stats();
            expected_stats_q.delete();
            fail_count   = 0;
            pending      = 0;
            result_index = 0;
        end
        else begin
            if (result.valid && result.ready) begin
                got = result.data;
                if (expected_stats_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat %0d: %h", result_index, got);
                end
                else begin
                    want = expected_stats_q.pop_front();
                    check_field("count", 64'(want.count), 64'(got.count));
                    check_field("total", 64'(want.total), 64'(got.total));
                    check_field("total_squares", 64'(want.total_squares),
                                64'(got.total_squares));
                    check_field("smallest", 64'(want.smallest), 64'(got.smallest));
                    check_field("largest", 64'(want.largest), 64'(got.largest));
                    check_field("all_equal", 64'(want.all_equal), 64'(got.all_equal));
                    check_field("average", 64'(want.average), 64'(got.average));
                    check_field("pop_variance", 64'(want.pop_variance),
                                64'(got.pop_variance));
                    check_field("unbiased_variance", 64'(want.unbiased_variance),
                                64'(got.unbiased_variance));
                    check_field("full_res", 64'(want.full_res), 64'(got.full_res));
                end
                result_index++;
            end
            if (item.valid && item.ready)
                expected_stats_q.push_back(advance_stats(item.data));
            pending = expected_stats_q.size();
        end
    end

endmodule

FILE: tb/tb_running_statistics_accumulator.sv
// tb_running_statistics_accumulator: stimulus, handshake pacing and verdict for the
// running statistics accumulator; depends on rsa_pkg, rsa_if and rsa_stats_checker

module tb_running_statistics_accumulator;
    timeunit 1ns;
    timeprecision 1ps;

    import rsa_pkg::*;

    // flavor of the samples inside one stretch between clears
    typedef enum int {
        MIX_FULL,
        MIX_SMALL,
        MIX_EXTREME,
        MIX_CONST,
        MIX_EDGE
    } sample_mix_t;

    localparam int RANDOM_ITEMS = 650;
    localparam int LONG_HOLD    = 700;   // several item times, so the block backs up
    localparam int DRAIN_CYCLES = 300;   // idle time after the last result, to catch stray beats

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;

    // pacing knobs shared by the sender and the receiver
    int   tx_idle_max = 12;
    int   rx_idle_max = 12;
    logic hold_long   = 1'b0;

    rsa_item_if   item_ch ();
    rsa_result_if result_ch ();

    running_statistics_accumulator u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    rsa_stats_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // single reset at the start, released on a falling edge
    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // hard stop in case the block hangs
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // offers one beat after a random gap and returns on the falling edge after it is taken;
    // valid stays high across back-to-back beats so it never toggles within one step
    task automatic send_item(rsa_in_t it);
        int gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        do @(posedge clk); while (!item_ch.ready);
        @(negedge clk);
    endtask

    // sender pause: nothing new until every predicted result has come back
    task automatic wait_drained();
        do @(negedge clk); while (pending != 0);
    endtask

    // receiver: random stall per beat, plus one long hold-off on request
    initial
    begin : receiver
        int stall;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_long)
            begin
                // long stretch with ready low while the sender keeps offering
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_long = 1'b0;
            end
            stall = $urandom_range(0, rx_idle_max);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        rsa_in_t                       directed_q[$];
        rsa_in_t                       it;
        sample_mix_t                   mix;
        logic signed [SAMPLE_BITS-1:0] run_val;

        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        mix     = MIX_FULL;
        run_val = '0;

        // directed part
        // clear on an empty accumulator, with a sample that must be ignored
        directed_q.push_back('{ACT_CLEAR, SMP_MAX});
        // single sample: unbiased variance stays 0, all-equal set
        directed_q.push_back('{ACT_ADD, 16'sd0});
        directed_q.push_back('{ACT_ADD, 16'sd0});
        // first differing sample drops all-equal
        directed_q.push_back('{ACT_ADD, -16'sd1});
        directed_q.push_back('{ACT_CLEAR, SMP_MIN});
        // extremes of the sample range, largest spread
        directed_q.push_back('{ACT_ADD, SMP_MIN});
        directed_q.push_back('{ACT_ADD, SMP_MIN});
        directed_q.push_back('{ACT_ADD, SMP_MAX});
        directed_q.push_back('{ACT_ADD, SMP_MAX});
        directed_q.push_back('{ACT_CLEAR, 16'sd0});
        directed_q.push_back('{ACT_ADD, SMP_MAX});
        directed_q.push_back('{ACT_ADD, SMP_MIN});
        directed_q.push_back('{ACT_ADD, -16'sd3});
        directed_q.push_back('{ACT_ADD, 16'sd7});
        directed_q.push_back('{ACT_CLEAR, -16'sd1});
        // constant run, then a break; first sample after clear sets all-equal again
        directed_q.push_back('{ACT_ADD, 16'sd5});
        directed_q.push_back('{ACT_ADD, 16'sd5});
        directed_q.push_back('{ACT_ADD, 16'sd5});
        directed_q.push_back('{ACT_ADD, 16'sd6});
        directed_q.push_back('{ACT_CLEAR, 16'sd21845});
        // negative mean truncates toward zero
        directed_q.push_back('{ACT_ADD, -16'sd1});
        directed_q.push_back('{ACT_ADD, -16'sd2});
        directed_q.push_back('{ACT_ADD, 16'sd1});

        @(posedge rst_n);
        @(negedge clk);
        foreach (directed_q[i])
            send_item(directed_q[i]);
        item_ch.valid <= 1'b0;
        wait_drained();

        // random part: stretches between clears, each with its own sample flavor
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            // alternate paced stretches with ones at full speed
            if (k % 100 == 50)
            begin
                tx_idle_max = 0;
                rx_idle_max = 0;
            end
            else if (k % 100 == 0)
            begin
                tx_idle_max = 12;
                rx_idle_max = 12;
            end
            // receiver backs off while items keep coming, filling the block
            if (k == 300)
            begin
                tx_idle_max = 0;
                hold_long   = 1'b1;
            end
            // sender drops valid and waits for the pipe to empty before going on
            if (k == 450)
            begin
                item_ch.valid <= 1'b0;
                wait_drained();
            end

            if ($urandom_range(0, 99) < 5)
            begin
                it.action = ACT_CLEAR;
                it.sample = SAMPLE_BITS'($urandom);
                mix       = sample_mix_t'($urandom_range(0, MIX_EDGE));
                run_val   = SAMPLE_BITS'($urandom);
            end
            else
            begin
                if ($urandom_range(0, 29) == 0)
                    mix = sample_mix_t'($urandom_range(0, MIX_EDGE));
                it.action = ACT_ADD;
                case (mix)
                    MIX_SMALL:
                        it.sample = SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
                    MIX_EXTREME:
                        it.sample = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
                    MIX_CONST:
                        // mostly a repeated value, broken now and then
                        it.sample = ($urandom_range(0, 14) == 0) ? SAMPLE_BITS'($urandom)
                                                                 : run_val;
                    MIX_EDGE:
                        it.sample = $urandom_range(0, 1)
                                    ? SMP_MAX - SAMPLE_BITS'($urandom_range(0, 3))
                                    : SMP_MIN + SAMPLE_BITS'($urandom_range(0, 3));
                    default:
                        it.sample = SAMPLE_BITS'($urandom);
                endcase
            end
            send_item(it);
        end
        item_ch.valid <= 1'b0;

        // let every result come home, then watch for strays
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
sv/rsa_pkg.sv
sv/rsa_if.sv
sv/rsa_stats.sv
sv/rsa_alu.sv
sv/rsa_seq.sv
sv/running_statistics_accumulator.sv
sv/rsa_checker.sv
tb/rsa_stats_checker.sv
tb/tb_running_statistics_accumulator.sv
